// ----- src/lsvm_pkg.sv -----
// Shared types and constants of the looping sample voice mixer.
// No dependencies; the datapath, controller, top and testbench refer to it by scoped names.
package lsvm_pkg;

  localparam int SAMPLE_W = 16;
  localparam int RATE_W   = 18;
  localparam int CHAN_W   = 4;
  localparam int FRAC_W   = 16;
  localparam int STEP_W   = RATE_W + FRAC_W;
  localparam int CURSOR_W = 36;
  localparam int FRAME_W  = CURSOR_W - FRAC_W;
  localparam int PROD_W   = FRAME_W + CHAN_W;
  localparam int SUM_W    = PROD_W + 2;

  // request commands
  localparam logic [1:0] CMD_PUSH  = 2'd0;
  localparam logic [1:0] CMD_TICK  = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;

  // result kinds
  localparam logic [1:0] KIND_SAMPLE = 2'd0;
  localparam logic [1:0] KIND_ACCEPT = 2'd1;
  localparam logic [1:0] KIND_REJECT = 2'd2;

  // configuration register indexes
  localparam logic REG_OUT_CHANNELS = 1'b0;
  localparam logic REG_TARGET_RATE  = 1'b1;

  localparam logic [1:0]        OUT_CHANNELS_RESET = 2'd2;
  localparam logic [RATE_W-1:0] TARGET_RATE_RESET  = 18'd48000;

  // divider operand selection
  localparam logic [1:0] DIV_FRAMES = 2'd0;
  localparam logic [1:0] DIV_STEP   = 2'd1;
  localparam logic [1:0] DIV_MOD    = 2'd2;

  typedef struct packed {
    logic [1:0]          command;
    logic signed [15:0]  sample_value;
    logic                last_sample;
    logic [CHAN_W-1:0]   source_channels;
    logic [RATE_W-1:0]   source_rate;
  } req_t;

  typedef struct packed {
    logic [1:0]          result_kind;
    logic signed [15:0]  sample_out;
    logic                last_in_frame;
  } rsp_t;

  // controller to datapath
  typedef struct packed {
    logic       take;
    logic       push;
    logic       clear;
    logic       release_src;
    logic       div_start;
    logic [1:0] div_sel;
    logic       frames_cap;
    logic       add_voice;
    logic       tick_start;
    logic       vread;
    logic       vcap;
    logic       frame_load;
    logic       mod_cap;
    logic       mul;
    logic       sread;
    logic       sacc;
    logic       ch_next;
    logic       vwrite;
    logic       emit;
    logic [1:0] kind;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [1:0] req_cmd;
    logic       req_last;
    logic       bad;
    logic       frames_zero;
    logic       div_busy;
    logic       frame_ge;
    logic       voices_done;
    logic       nch2;
    logic       ch;
    logic       out_busy;
  } sts_t;

endpackage

// ----- src/lsvm_ram.sv -----
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module lsvm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                                     clk,
  input  logic                                     wr_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                         wr_data,
  input  logic                                     rd_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- src/lsvm_div.sv -----
// Restoring unsigned divider, one quotient bit per cycle.
// No dependencies.
module lsvm_div #(
  parameter int NW = 34,
  parameter int DW = 21
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] dividend,
  input  logic [DW-1:0] divisor,
  output logic          busy,
  output logic [NW-1:0] quo,
  output logic [DW-1:0] rem
);

  localparam int CW = $clog2(NW + 1);

  logic [CW-1:0] cnt;
  logic [DW:0]   trial;
  logic          fit;

  assign trial = {rem, quo[NW-1]};
  assign fit   = trial >= {1'b0, divisor};

  // shift in one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CW'(NW);
      quo  <= dividend;
      rem  <= '0;
    end else if (busy) begin
      quo  <= {quo[NW-2:0], fit};
      rem  <= fit ? DW'(trial - {1'b0, divisor}) : DW'(trial);
      cnt  <= cnt - 1'b1;
      busy <= cnt != CW'(1);
    end
  end

endmodule

// ----- src/lsvm_datapath.sv -----
// Datapath: configuration, sample store, voice table, divider, mix and result register.
// Depends on lsvm_pkg, lsvm_ram and lsvm_div.
module lsvm_datapath #(
  parameter int STORE_WORDS      = 65536,
  parameter int VOICES           = 8,
  parameter int MAX_SRC_CHANNELS = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  lsvm_pkg::req_t      req_data,
  input  logic                cfg_valid,
  input  logic                cfg_index,
  input  logic [17:0]         cfg_data,
  input  logic                rsp_stall,
  input  lsvm_pkg::cmd_t      cmd,
  output lsvm_pkg::sts_t      sts,
  output logic                rsp_valid,
  output lsvm_pkg::rsp_t      rsp_data
);

  localparam int AW     = STORE_WORDS > 1 ? $clog2(STORE_WORDS) : 1;
  localparam int FILL_W = AW + 1;
  localparam int VW     = VOICES > 1 ? $clog2(VOICES) : 1;
  localparam int VCW    = $clog2(VOICES + 1);
  localparam int ACC_W  = lsvm_pkg::SAMPLE_W + 1 + $clog2(VOICES);
  localparam int DIV_W  = FILL_W > lsvm_pkg::RATE_W ? FILL_W : lsvm_pkg::RATE_W;
  localparam int NUM_W  = lsvm_pkg::STEP_W;
  localparam int VE_W   = AW + FILL_W + lsvm_pkg::CHAN_W + lsvm_pkg::STEP_W
                          + lsvm_pkg::CURSOR_W;

  lsvm_pkg::req_t lat;
  logic [1:0]                          out_ch;
  logic [lsvm_pkg::RATE_W-1:0]         trate;
  logic [FILL_W-1:0]                   fill;
  logic [FILL_W-1:0]                   pstart;
  logic                                ovf;
  logic [VCW-1:0]                      vcount;
  logic [VCW-1:0]                      v;
  logic                                ch;
  logic signed [ACC_W-1:0]             acc0;
  logic signed [ACC_W-1:0]             acc1;
  logic [AW-1:0]                       w_base;
  logic [FILL_W-1:0]                   w_frames;
  logic [lsvm_pkg::CHAN_W-1:0]         w_chans;
  logic [lsvm_pkg::STEP_W-1:0]         w_step;
  logic [lsvm_pkg::CURSOR_W-1:0]       w_cursor;
  logic [lsvm_pkg::FRAME_W-1:0]        frame;
  logic [lsvm_pkg::PROD_W-1:0]         prod;
  logic [FILL_W-1:0]                   frames;
  logic                                addr_ok;

  logic [FILL_W-1:0]                   count;
  logic [lsvm_pkg::RATE_W-1:0]         tr_eff;
  logic [NUM_W-1:0]                    div_num;
  logic [DIV_W-1:0]                    div_den;
  logic                                div_busy;
  logic [NUM_W-1:0]                    div_quo;
  logic [DIV_W-1:0]                    div_rem;
  logic [lsvm_pkg::FRAME_W-1:0]        frame_w;
  logic [lsvm_pkg::FRAME_W-1:0]        frame_rem;
  logic                                sc;
  logic [lsvm_pkg::SUM_W-1:0]          addr_sum;
  logic                                bad;
  logic [VE_W-1:0]                     vram_wr;
  logic [VE_W-1:0]                     vram_rd;
  logic [VW-1:0]                       vram_waddr;
  logic [AW-1:0]                       e_base;
  logic [FILL_W-1:0]                   e_frames;
  logic [lsvm_pkg::CHAN_W-1:0]         e_chans;
  logic [lsvm_pkg::STEP_W-1:0]         e_step;
  logic [lsvm_pkg::CURSOR_W-1:0]       e_cursor;
  logic [lsvm_pkg::SAMPLE_W-1:0]       sram_rd;
  logic signed [ACC_W-1:0]             acc_sel;
  logic signed [15:0]                  clamped;
  logic                                nch2;

  assign nch2    = out_ch[1];
  assign count   = fill - pstart;
  assign tr_eff  = (trate == '0) ? lsvm_pkg::RATE_W'(1) : trate;
  assign frame_w = w_cursor[lsvm_pkg::CURSOR_W-1:lsvm_pkg::FRAC_W];
  assign frame_rem = lsvm_pkg::FRAME_W'(div_rem);
  assign sc      = ch && (w_chans > lsvm_pkg::CHAN_W'(1));
  assign addr_sum = lsvm_pkg::SUM_W'(w_base) + lsvm_pkg::SUM_W'(prod)
                    + lsvm_pkg::SUM_W'(sc);
  assign bad = ovf || (lat.source_channels == '0)
               || (32'(lat.source_channels) > 32'(MAX_SRC_CHANNELS))
               || (32'(vcount) >= 32'(VOICES));

  // select divider operands
  always_comb begin
    case (cmd.div_sel)
      lsvm_pkg::DIV_FRAMES: begin
        div_num = NUM_W'(count);
        div_den = DIV_W'(lat.source_channels);
      end
      lsvm_pkg::DIV_STEP: begin
        div_num = {lat.source_rate, lsvm_pkg::FRAC_W'(0)};
        div_den = DIV_W'(tr_eff);
      end
      lsvm_pkg::DIV_MOD: begin
        div_num = NUM_W'(frame_w);
        div_den = DIV_W'(w_frames);
      end
      default: begin
        div_num = '0;
        div_den = DIV_W'(1);
      end
    endcase
  end

  lsvm_div #(.NW(NUM_W), .DW(DIV_W)) u_div (
    .clk(clk), .rst(rst), .start(cmd.div_start), .dividend(div_num),
    .divisor(div_den), .busy(div_busy), .quo(div_quo), .rem(div_rem)
  );

  // sample store
  lsvm_ram #(.WIDTH(lsvm_pkg::SAMPLE_W), .DEPTH(STORE_WORDS)) u_store (
    .clk(clk),
    .wr_en(cmd.push && !ovf && (fill < FILL_W'(STORE_WORDS))),
    .wr_addr(fill[AW-1:0]), .wr_data(lat.sample_value),
    .rd_en(cmd.sread), .rd_addr(addr_sum[AW-1:0]), .rd_data(sram_rd)
  );

  // voice table, one packed entry per voice
  assign vram_waddr = cmd.add_voice ? vcount[VW-1:0] : v[VW-1:0];
  always_comb begin
    if (cmd.add_voice) begin
      vram_wr = {pstart[AW-1:0], frames, lat.source_channels, div_quo,
                 lsvm_pkg::CURSOR_W'(0)};
    end else begin
      vram_wr = {w_base, w_frames, w_chans, w_step,
                 w_cursor + lsvm_pkg::CURSOR_W'(w_step)};
    end
  end
  assign {e_base, e_frames, e_chans, e_step, e_cursor} = vram_rd;

  lsvm_ram #(.WIDTH(VE_W), .DEPTH(VOICES)) u_voices (
    .clk(clk), .wr_en(cmd.add_voice || cmd.vwrite), .wr_addr(vram_waddr),
    .wr_data(vram_wr), .rd_en(cmd.vread), .rd_addr(v[VW-1:0]), .rd_data(vram_rd)
  );

  // clamp the selected channel sum to Q1.15
  assign acc_sel = ch ? acc1 : acc0;
  always_comb begin
    if (acc_sel > $signed(ACC_W'(32767))) begin
      clamped = 16'sh7FFF;
    end else if (acc_sel < $signed(-ACC_W'(32768))) begin
      clamped = -16'sh8000;
    end else begin
      clamped = acc_sel[15:0];
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch <= lsvm_pkg::OUT_CHANNELS_RESET;
      trate  <= lsvm_pkg::TARGET_RATE_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        lsvm_pkg::REG_OUT_CHANNELS: out_ch <= cfg_data[1:0];
        lsvm_pkg::REG_TARGET_RATE:  trate  <= cfg_data;
        default: ;
      endcase
    end
  end

  // store and voice bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      fill   <= '0;
      pstart <= '0;
      ovf    <= 1'b0;
      vcount <= '0;
    end else if (cmd.clear) begin
      fill   <= '0;
      pstart <= '0;
      ovf    <= 1'b0;
      vcount <= '0;
    end else if (cmd.push) begin
      if (!ovf && (fill < FILL_W'(STORE_WORDS))) begin
        fill <= fill + 1'b1;
      end else begin
        ovf <= 1'b1;
      end
    end else if (cmd.release_src) begin
      fill <= pstart;
      ovf  <= 1'b0;
    end else if (cmd.add_voice) begin
      pstart <= fill;
      ovf    <= 1'b0;
      vcount <= vcount + 1'b1;
    end
  end

  // request latch and per-voice working registers
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      lat <= req_data;
    end
    if (cmd.frames_cap) begin
      frames <= FILL_W'(div_quo);
    end
    if (cmd.vcap) begin
      w_base   <= e_base;
      w_frames <= e_frames;
      w_chans  <= e_chans;
      w_step   <= e_step;
      w_cursor <= e_cursor;
    end
    if (cmd.frame_load) begin
      frame <= frame_w;
    end
    if (cmd.mod_cap) begin
      frame    <= frame_rem;
      w_cursor <= {frame_rem, lsvm_pkg::FRAC_W'(0)};
    end
    if (cmd.mul) begin
      prod <= lsvm_pkg::PROD_W'(frame) * lsvm_pkg::PROD_W'(w_chans);
    end
    if (cmd.sread) begin
      addr_ok <= addr_sum < lsvm_pkg::SUM_W'(STORE_WORDS);
    end
  end

  // voice walk and channel accumulators
  always_ff @(posedge clk) begin
    if (rst) begin
      v  <= '0;
      ch <= 1'b0;
    end else if (cmd.tick_start) begin
      v    <= '0;
      ch   <= 1'b0;
      acc0 <= '0;
      acc1 <= '0;
    end else begin
      if (cmd.sacc && addr_ok) begin
        if (ch) begin
          acc1 <= acc1 + ACC_W'($signed(sram_rd));
        end else begin
          acc0 <= acc0 + ACC_W'($signed(sram_rd));
        end
      end
      if (cmd.ch_next) begin
        ch <= ~ch;
      end
      if (cmd.vwrite) begin
        v  <= v + 1'b1;
        ch <= 1'b0;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.emit) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      rsp_data.result_kind <= cmd.kind;
      if (cmd.kind == lsvm_pkg::KIND_SAMPLE) begin
        rsp_data.sample_out    <= clamped;
        rsp_data.last_in_frame <= ch || !nch2;
      end else begin
        rsp_data.sample_out    <= '0;
        rsp_data.last_in_frame <= 1'b0;
      end
    end
  end

  // status to controller
  always_comb begin
    sts.req_cmd     = lat.command;
    sts.req_last    = lat.last_sample;
    sts.bad         = bad;
    sts.frames_zero = frames == '0;
    sts.div_busy    = div_busy;
    sts.frame_ge    = 32'(frame_w) >= 32'(w_frames);
    sts.voices_done = v == vcount;
    sts.nch2        = nch2;
    sts.ch          = ch;
    sts.out_busy    = rsp_valid && rsp_stall;
  end

  a_fill_order: assert property (@(posedge clk) disable iff (rst)
    (pstart <= fill) && (fill <= FILL_W'(STORE_WORDS)))
    else $error("store fill below pending start or beyond store");
  a_voice_limit: assert property (@(posedge clk) disable iff (rst)
    32'(vcount) <= 32'(VOICES))
    else $error("voice count beyond table");
  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> !(rsp_valid && rsp_stall))
    else $error("result overwritten while stalled");
  a_div_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.div_start |-> !div_busy)
    else $error("divider restarted while busy");

endmodule

// ----- src/lsvm_ctrl.sv -----
// Controller state machine: sequences pushes, source close, ticks and results.
// Depends on lsvm_pkg.
module lsvm_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  lsvm_pkg::sts_t sts,
  output lsvm_pkg::cmd_t cmd
);

  localparam logic [4:0] S_IDLE      = 5'd0;
  localparam logic [4:0] S_DECODE    = 5'd1;
  localparam logic [4:0] S_CLOSE     = 5'd2;
  localparam logic [4:0] S_DIVF_WAIT = 5'd3;
  localparam logic [4:0] S_FCHK      = 5'd4;
  localparam logic [4:0] S_DIVS_WAIT = 5'd5;
  localparam logic [4:0] S_ACK_OK    = 5'd6;
  localparam logic [4:0] S_ACK_BAD   = 5'd7;
  localparam logic [4:0] S_VRD       = 5'd8;
  localparam logic [4:0] S_VCAP      = 5'd9;
  localparam logic [4:0] S_VCHK      = 5'd10;
  localparam logic [4:0] S_VMOD      = 5'd11;
  localparam logic [4:0] S_VMUL      = 5'd12;
  localparam logic [4:0] S_SRD       = 5'd13;
  localparam logic [4:0] S_SACC      = 5'd14;
  localparam logic [4:0] S_VWR       = 5'd15;
  localparam logic [4:0] S_EMIT      = 5'd16;
  localparam logic [4:0] S_PUSH      = 5'd17;

  logic [4:0] state;
  logic [4:0] state_next;

  assign req_stall = state != S_IDLE;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and datapath commands
  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.take   = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        case (sts.req_cmd)
          lsvm_pkg::CMD_PUSH: state_next = S_PUSH;
          lsvm_pkg::CMD_TICK: begin
            cmd.tick_start = 1'b1;
            state_next     = S_VRD;
          end
          lsvm_pkg::CMD_CLEAR: begin
            cmd.clear  = 1'b1;
            state_next = S_IDLE;
          end
          default: state_next = S_IDLE;
        endcase
      end
      S_PUSH: begin
        cmd.push   = 1'b1;
        state_next = sts.req_last ? S_CLOSE : S_IDLE;
      end
      S_CLOSE: begin
        if (sts.bad) begin
          cmd.release_src = 1'b1;
          state_next      = S_ACK_BAD;
        end else begin
          cmd.div_start = 1'b1;
          cmd.div_sel   = lsvm_pkg::DIV_FRAMES;
          state_next    = S_DIVF_WAIT;
        end
      end
      S_DIVF_WAIT: begin
        if (!sts.div_busy) begin
          cmd.frames_cap = 1'b1;
          state_next     = S_FCHK;
        end
      end
      S_FCHK: begin
        if (sts.frames_zero) begin
          cmd.release_src = 1'b1;
          state_next      = S_ACK_OK;
        end else begin
          cmd.div_start = 1'b1;
          cmd.div_sel   = lsvm_pkg::DIV_STEP;
          state_next    = S_DIVS_WAIT;
        end
      end
      S_DIVS_WAIT: begin
        // hold the rate divisor while the step division runs
        cmd.div_sel = lsvm_pkg::DIV_STEP;
        if (!sts.div_busy) begin
          cmd.add_voice = 1'b1;
          state_next    = S_ACK_OK;
        end
      end
      S_ACK_OK: begin
        if (!sts.out_busy) begin
          cmd.emit   = 1'b1;
          cmd.kind   = lsvm_pkg::KIND_ACCEPT;
          state_next = S_IDLE;
        end
      end
      S_ACK_BAD: begin
        if (!sts.out_busy) begin
          cmd.emit   = 1'b1;
          cmd.kind   = lsvm_pkg::KIND_REJECT;
          state_next = S_IDLE;
        end
      end
      S_VRD: begin
        if (sts.voices_done) begin
          state_next = S_EMIT;
        end else begin
          cmd.vread  = 1'b1;
          state_next = S_VCAP;
        end
      end
      S_VCAP: begin
        cmd.vcap   = 1'b1;
        state_next = S_VCHK;
      end
      S_VCHK: begin
        if (sts.frame_ge) begin
          cmd.div_start = 1'b1;
          cmd.div_sel   = lsvm_pkg::DIV_MOD;
          state_next    = S_VMOD;
        end else begin
          cmd.frame_load = 1'b1;
          state_next     = S_VMUL;
        end
      end
      S_VMOD: begin
        cmd.div_sel = lsvm_pkg::DIV_MOD;
        if (!sts.div_busy) begin
          cmd.mod_cap = 1'b1;
          state_next  = S_VMUL;
        end
      end
      S_VMUL: begin
        cmd.mul    = 1'b1;
        state_next = S_SRD;
      end
      S_SRD: begin
        cmd.sread  = 1'b1;
        state_next = S_SACC;
      end
      S_SACC: begin
        cmd.sacc = 1'b1;
        if (!sts.ch && sts.nch2) begin
          cmd.ch_next = 1'b1;
          state_next  = S_SRD;
        end else begin
          state_next = S_VWR;
        end
      end
      S_VWR: begin
        cmd.vwrite = 1'b1;
        state_next = S_VRD;
      end
      S_EMIT: begin
        if (!sts.out_busy) begin
          cmd.emit = 1'b1;
          cmd.kind = lsvm_pkg::KIND_SAMPLE;
          if (sts.ch || !sts.nch2) begin
            state_next = S_IDLE;
          end else begin
            cmd.ch_next = 1'b1;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// ----- src/looping_sample_voice_mixer.sv -----
// Looping sample voice mixer: pushes build looping voices in a shared sample
// store; each tick mixes one nearest-neighbor frame of every voice, clamped to
// Q1.15. One request is processed at a time. A closing push runs two 34-step
// divisions in the shared restoring divider (frame count, then Q18.16 step); a
// rejected source answers without a division, and one with no whole frame once
// the frame count division is done. A tick walks the voices one at a time via
// the single store read port, with one more read per voice for a second output
// channel; a voice whose cursor wraps also runs the wrap modulo in the divider.
// Results leave through a register, so a stalled result holds the next request
// only once a new result is ready. Depends on lsvm_pkg, lsvm_ctrl, lsvm_datapath.
module looping_sample_voice_mixer #(
  parameter int STORE_WORDS      = 65536,
  parameter int VOICES           = 8,
  parameter int MAX_SRC_CHANNELS = 8
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  lsvm_pkg::req_t req_data,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output lsvm_pkg::rsp_t rsp_data,
  input  logic           cfg_valid,
  output logic           cfg_ready,
  input  logic           cfg_index,
  input  logic [17:0]    cfg_data
);

  lsvm_pkg::cmd_t cmd;
  lsvm_pkg::sts_t sts;

  // registers always take a write
  assign cfg_ready = 1'b1;

  lsvm_ctrl u_ctrl (
    .clk(clk), .rst(rst), .req_valid(req_valid), .req_stall(req_stall),
    .sts(sts), .cmd(cmd)
  );

  lsvm_datapath #(
    .STORE_WORDS(STORE_WORDS), .VOICES(VOICES),
    .MAX_SRC_CHANNELS(MAX_SRC_CHANNELS)
  ) u_dp (
    .clk(clk), .rst(rst), .req_data(req_data), .cfg_valid(cfg_valid),
    .cfg_index(cfg_index), .cfg_data(cfg_data), .rsp_stall(rsp_stall),
    .cmd(cmd), .sts(sts), .rsp_valid(rsp_valid), .rsp_data(rsp_data)
  );

endmodule

// ----- tb/tb_looping_sample_voice_mixer.sv -----
// Testbench for the looping sample voice mixer: directed table, then random requests,
// every result checked against a behavioral mixer model. Depends on lsvm_pkg and the RTL.
`timescale 1ns / 100ps
module tb_looping_sample_voice_mixer;

  localparam int STORE_N = 65536;
  localparam int VOICE_N = 8;
  localparam int SRC_CH_MAX = 8;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  lsvm_pkg::req_t req_data = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  lsvm_pkg::rsp_t rsp_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_index = 1'b0;
  logic [17:0] cfg_data = '0;

  looping_sample_voice_mixer i_dut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // mixer model state
  logic [15:0] mix_store [STORE_N];
  int unsigned mix_fill, mix_pstart, mix_nvoice;
  bit          mix_ovf;
  int unsigned mix_base [VOICE_N];
  int unsigned mix_frames [VOICE_N];
  int unsigned mix_chans [VOICE_N];
  logic [35:0] mix_step [VOICE_N];
  logic [35:0] mix_cursor [VOICE_N];
  logic [1:0]  mix_outch;
  logic [17:0] mix_trate;

  lsvm_pkg::rsp_t expected_rsp [$];
  lsvm_pkg::rsp_t pred_first;
  bit   pred_seen = 1'b0;
  int   err_count = 0;
  bit   no_idle = 1'b0;
  bit   hold_rsp = 1'b0;
  bit   held = 1'b0;

  task automatic report(input string what, input lsvm_pkg::rsp_t got,
                        input lsvm_pkg::rsp_t want);
    $display("mismatch %s: got kind %0d sample %0d last %0d, want kind %0d sample %0d last %0d",
             what, got.result_kind, got.sample_out, got.last_in_frame,
             want.result_kind, want.sample_out, want.last_in_frame);
    err_count++;
  endtask

  function automatic lsvm_pkg::rsp_t mk_rsp(input logic [1:0] k, input int s, input bit l);
    lsvm_pkg::rsp_t r;
    r.result_kind = k;
    r.sample_out = s[15:0];
    r.last_in_frame = l;
    return r;
  endfunction

  // append one predicted result, remember the first of a request
  task automatic queue_rsp(input lsvm_pkg::rsp_t r);
    begin
      if (!pred_seen) begin
        pred_first = r;
        pred_seen = 1'b1;
      end
      expected_rsp.insert(expected_rsp.size(), r);
    end
  endtask

  // predict results of one accepted request
  task automatic mix_predict(input lsvm_pkg::req_t r);
    int unsigned nch, cnt, frm, tr, sc, v, ch;
    longint unsigned fidx, addr;
    int acc [2];
    bit bad;
    begin
      if (r.command == lsvm_pkg::CMD_PUSH) begin
        if (!mix_ovf && mix_fill < STORE_N) begin
          mix_store[mix_fill] = r.sample_value;
          mix_fill++;
        end else mix_ovf = 1'b1;
        if (r.last_sample) begin
          cnt = mix_fill - mix_pstart;
          tr = (mix_trate == 0) ? 1 : mix_trate;
          bad = mix_ovf || r.source_channels == 0 || r.source_channels > SRC_CH_MAX
                || mix_nvoice >= VOICE_N;
          mix_ovf = 1'b0;
          if (bad) begin
            mix_fill = mix_pstart;
            queue_rsp(mk_rsp(lsvm_pkg::KIND_REJECT, 0, 0));
          end else begin
            frm = cnt / r.source_channels;
            if (frm == 0) mix_fill = mix_pstart;
            else begin
              mix_base[mix_nvoice] = mix_pstart;
              mix_frames[mix_nvoice] = frm;
              mix_chans[mix_nvoice] = r.source_channels;
              mix_step[mix_nvoice] = ({18'd0, r.source_rate} << 16) / tr;
              mix_cursor[mix_nvoice] = '0;
              mix_nvoice++;
              mix_pstart = mix_fill;
            end
            queue_rsp(mk_rsp(lsvm_pkg::KIND_ACCEPT, 0, 0));
          end
        end
      end else if (r.command == lsvm_pkg::CMD_TICK) begin
        nch = (mix_outch == 0) ? 1 : ((mix_outch > 2) ? 2 : mix_outch);
        acc[0] = 0;
        acc[1] = 0;
        for (v = 0; v < mix_nvoice; v++) begin
          fidx = mix_cursor[v] >> 16;
          if (fidx >= mix_frames[v]) begin
            fidx = fidx % mix_frames[v];
            mix_cursor[v] = fidx << 16;
          end
          for (ch = 0; ch < nch; ch++) begin
            sc = (ch < mix_chans[v]) ? ch : mix_chans[v] - 1;
            addr = mix_base[v] + fidx * mix_chans[v] + sc;
            if (addr < STORE_N) acc[ch] += $signed(mix_store[addr]);
          end
          mix_cursor[v] = mix_cursor[v] + mix_step[v];
        end
        for (ch = 0; ch < nch; ch++) begin
          if (acc[ch] > 32767) acc[ch] = 32767;
          if (acc[ch] < -32768) acc[ch] = -32768;
          queue_rsp(mk_rsp(lsvm_pkg::KIND_SAMPLE, acc[ch], ch + 1 == nch));
        end
      end else if (r.command == lsvm_pkg::CMD_CLEAR) begin
        mix_nvoice = 0;
        mix_fill = 0;
        mix_pstart = 0;
        mix_ovf = 1'b0;
      end
    end
  endtask

  // check accepted results
  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) begin
      if (expected_rsp.size() == 0) begin
        report("unexpected", rsp_data, '0);
      end else begin
        if (rsp_data !== expected_rsp[0]) report("field", rsp_data, expected_rsp[0]);
        void'(expected_rsp.pop_front());
      end
    end
  end

  // receiver stall: random bursts, long hold when asked
  always @(posedge clk) begin
    int unsigned burst;
    if (hold_rsp) rsp_stall <= 1'b1;
    else if (no_idle) rsp_stall <= 1'b0;
    else if (burst > 0) begin
      burst--;
      if (burst == 0) rsp_stall <= 1'b0;
    end else if ($urandom_range(0, 5) == 0) begin
      burst = $urandom_range(1, 5);
      rsp_stall <= 1'b1;
    end else rsp_stall <= 1'b0;
  end

  task automatic send(input lsvm_pkg::req_t r);
    int unsigned gap;
    begin
      if (!no_idle && $urandom_range(0, 4) == 0) begin
        req_valid <= 1'b0;
        gap = $urandom_range(1, 5);
        repeat (gap) @(posedge clk);
      end
      req_data <= r;
      req_valid <= 1'b1;
      @(posedge clk);
      while (req_stall) @(posedge clk);
      pred_seen = 1'b0;
      mix_predict(r);
    end
  endtask

  task automatic drain();
    begin
      req_valid <= 1'b0;
      while (expected_rsp.size() != 0) @(posedge clk);
      repeat (400) @(posedge clk);
    end
  endtask

  task automatic write_reg(input logic idx, input logic [17:0] val);
    begin
      cfg_index <= idx;
      cfg_data <= val;
      cfg_valid <= 1'b1;
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      cfg_valid <= 1'b0;
      if (idx == lsvm_pkg::REG_OUT_CHANNELS) mix_outch = val[1:0];
      else mix_trate = val;
      @(posedge clk);
    end
  endtask

  function automatic lsvm_pkg::req_t mk_req(input logic [1:0] c, input int s, input bit l,
                                            input int ch, input int rate);
    lsvm_pkg::req_t r;
    r.command = c;
    r.sample_value = s[15:0];
    r.last_sample = l;
    r.source_channels = ch[3:0];
    r.source_rate = rate[17:0];
    return r;
  endfunction

  function automatic lsvm_pkg::req_t rand_req();
    lsvm_pkg::req_t r;
    r.command = $urandom_range(0, 3);
    r.sample_value = $urandom;
    r.last_sample = $urandom_range(0, 7) == 0;
    r.source_channels = $urandom;
    r.source_rate = $urandom;
    return r;
  endfunction

  // push one well-formed source with random content
  task automatic push_source(input int frames, input int chans, input int rate);
    int n;
    begin
      for (n = 0; n < frames * chans; n++)
        send(mk_req(lsvm_pkg::CMD_PUSH, $urandom, n == frames * chans - 1, chans, rate));
    end
  endtask

  typedef struct {
    lsvm_pkg::req_t r;
    bit             chk;
    lsvm_pkg::rsp_t want;
  } row_t;

  row_t dir_rows [$];
  int   issued = 0;

  task automatic add_row(input lsvm_pkg::req_t r, input bit chk, input lsvm_pkg::rsp_t want);
    row_t row;
    begin
      row.r = r;
      row.chk = chk;
      row.want = want;
      dir_rows.insert(dir_rows.size(), row);
    end
  endtask

  initial begin
    int i, k, frames, chans, rate;
    mix_fill = 0; mix_pstart = 0; mix_nvoice = 0; mix_ovf = 0;
    mix_outch = lsvm_pkg::OUT_CHANNELS_RESET;
    mix_trate = lsvm_pkg::TARGET_RATE_RESET;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table
    add_row(mk_req(lsvm_pkg::CMD_TICK, 0, 0, 1, 1), 1,
            mk_rsp(lsvm_pkg::KIND_SAMPLE, 0, 0));
    add_row(mk_req(lsvm_pkg::CMD_PUSH, 32767, 1, 0, 1), 1,
            mk_rsp(lsvm_pkg::KIND_REJECT, 0, 0));
    add_row(mk_req(lsvm_pkg::CMD_PUSH, -32768, 1, 9, 1), 1,
            mk_rsp(lsvm_pkg::KIND_REJECT, 0, 0));
    add_row(mk_req(lsvm_pkg::CMD_PUSH, 5, 1, 2, 100), 1,
            mk_rsp(lsvm_pkg::KIND_ACCEPT, 0, 0));
    add_row(mk_req(lsvm_pkg::CMD_PUSH, 32767, 0, 1, 0), 0, '0);
    add_row(mk_req(lsvm_pkg::CMD_PUSH, 32767, 1, 1, 200000), 0, '0);
    add_row(mk_req(lsvm_pkg::CMD_PUSH, 32767, 0, 1, 0), 0, '0);
    add_row(mk_req(lsvm_pkg::CMD_PUSH, -32768, 1, 1, 0), 0, '0);
    add_row(mk_req(lsvm_pkg::CMD_PUSH, 32767, 1, 15, 262143), 0, '0);
    add_row(mk_req(lsvm_pkg::CMD_TICK, 0, 0, 0, 0), 0, '0);
    add_row(mk_req(lsvm_pkg::CMD_TICK, 0, 0, 0, 0), 0, '0);
    add_row(mk_req(2'd3, -1, 1, 15, 262143), 0, '0);
    add_row(mk_req(lsvm_pkg::CMD_TICK, 0, 0, 0, 0), 0, '0);
    add_row(mk_req(lsvm_pkg::CMD_CLEAR, 0, 0, 0, 0), 0, '0);
    add_row(mk_req(lsvm_pkg::CMD_TICK, 0, 0, 0, 0), 0, '0);
    foreach (dir_rows[i]) begin
      send(dir_rows[i].r);
      // a tick row has two results; only the first is typed in
      if (dir_rows[i].chk) begin
        if (!pred_seen) report("table", '0, dir_rows[i].want);
        else if (pred_first !== dir_rows[i].want) report("table", pred_first, dir_rows[i].want);
      end
      issued++;
    end
    drain();

    // several register settings, extremes among them
    for (k = 0; k < 6; k++) begin
      case (k)
        0: begin
          write_reg(lsvm_pkg::REG_OUT_CHANNELS, 1);
          write_reg(lsvm_pkg::REG_TARGET_RATE, 1);
        end
        1: begin
          write_reg(lsvm_pkg::REG_OUT_CHANNELS, 2);
          write_reg(lsvm_pkg::REG_TARGET_RATE, 200000);
        end
        2: begin
          write_reg(lsvm_pkg::REG_OUT_CHANNELS, 0);
          write_reg(lsvm_pkg::REG_TARGET_RATE, 0);
        end
        3: begin
          write_reg(lsvm_pkg::REG_OUT_CHANNELS, 3);
          write_reg(lsvm_pkg::REG_TARGET_RATE, 262143);
        end
        4: begin
          write_reg(lsvm_pkg::REG_OUT_CHANNELS, 2);
          write_reg(lsvm_pkg::REG_TARGET_RATE, 44100);
        end
        default: begin
          write_reg(lsvm_pkg::REG_OUT_CHANNELS, $urandom_range(1, 2));
          write_reg(lsvm_pkg::REG_TARGET_RATE, $urandom_range(1, 200000));
        end
      endcase
      send(mk_req(lsvm_pkg::CMD_CLEAR, 0, 0, 0, 0));
      if (k == 5) no_idle = 1'b1;
      while (issued < 15 + (k + 1) * 108) begin
        case ($urandom_range(0, 9))
          0, 1, 2: begin
            frames = ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 6);
            chans = $urandom_range(1, 3);
            rate = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 200000);
            if (frames == 0) send(mk_req(lsvm_pkg::CMD_PUSH, $urandom, 1, chans + 1, rate));
            else push_source(frames, chans, rate);
            issued += (frames == 0) ? 1 : frames * chans;
          end
          3, 4, 5, 6: begin
            send(mk_req(lsvm_pkg::CMD_TICK, $urandom, $urandom, $urandom, $urandom));
            issued++;
          end
          7: begin
            if ($urandom_range(0, 3) == 0) send(mk_req(lsvm_pkg::CMD_CLEAR, $urandom, 0, 0, 0));
            else send(rand_req());
            issued++;
          end
          default: begin
            send(rand_req());
            issued++;
          end
        endcase
        // long receiver hold while ticks keep coming
        if (k == 2 && !held && issued > 280) begin
          held = 1'b1;
          hold_rsp = 1'b1;
          // release the receiver after a long fixed stretch
          fork
            begin repeat (300) @(posedge clk); hold_rsp = 1'b0; end
          join_none
          for (i = 0; i < 6; i++) begin
            req_data <= mk_req(lsvm_pkg::CMD_TICK, 0, 0, 0, 0);
            req_valid <= 1'b1;
            @(posedge clk);
            while (req_stall) @(posedge clk);
            pred_seen = 1'b0;
            mix_predict(mk_req(lsvm_pkg::CMD_TICK, 0, 0, 0, 0));
            issued++;
          end
          req_valid <= 1'b0;
          // sender pauses until everything is back
          while (expected_rsp.size() != 0) @(posedge clk);
        end
      end
      drain();
    end

    if (err_count == 0) $display("[looping_sample_voice_mixer] OK");
    else $display("[looping_sample_voice_mixer] ERROR");
    $finish;
  end

  initial begin
    #40ms;
    $display("[looping_sample_voice_mixer] ERROR");
    $finish;
  end

endmodule
